### design/edge_set_closest_point_core_macros.svh
// Assertion macros for the edge set closest point core.
`ifndef EDGE_SET_CLOSEST_POINT_CORE_MACROS_SVH
`define EDGE_SET_CLOSEST_POINT_CORE_MACROS_SVH
`ifndef SYNTH
`define ESCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ESCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ESCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ESCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/escp_pkg.sv
// Shared types and constants for the edge set closest point core.
package escp_pkg;
    localparam int unsigned CoordW = 24;
    localparam int unsigned DistW  = 53;
    localparam int unsigned FracW  = 24;
    localparam int unsigned DiffW  = 25;
    localparam int unsigned DotW   = 53;

    localparam int unsigned VertexDepth = 256;
    localparam int unsigned EdgeDepth   = 256;

    typedef enum logic [1:0] {
        REQ_VERTEX = 2'd0,
        REQ_EDGE   = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH_E, ST_FETCH_V, ST_DIFF, ST_MAC, ST_DECIDE,
        ST_DIV, ST_PROJ, ST_DIST, ST_CMP, ST_DONE
    } t_state;
endpackage

### design/escp_divider.sv
// Restoring divider: floor(num * 2^24 / den) for 0 < num < den, one bit per cycle.
module escp_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [escp_pkg::DotW-1:0]         i_num,
    input  logic [escp_pkg::DotW-1:0]         i_den,
    output logic                              o_done,
    output logic [escp_pkg::FracW-1:0]        o_quot
);
    logic [escp_pkg::DotW:0]    r_rem;
    logic [escp_pkg::DotW-1:0]  r_den;
    logic [escp_pkg::FracW-1:0] r_quot;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [escp_pkg::DotW:0]    n_shift;
    logic                       n_ge;

    always_comb begin
        n_shift = {r_rem[escp_pkg::DotW-1:0], 1'b0};
        n_ge    = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(escp_pkg::FracW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_shift - {1'b0, r_den} : n_shift;
            r_quot <= {r_quot[escp_pkg::FracW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### design/edge_set_closest_point_core.sv
// Top level: vertex and edge tables, per-edge sequencer over one shared multiplier.
// Write and ignored items leave the core idle; the next item can be accepted right after.
// A query runs the per-edge sequence for each searched edge, with the 24-step divider
// only when the projection falls inside the edge; the result strobe follows the last edge.
// Start is taken again in the strobe cycle.
// Synchronous active-low reset clears control and sets edge_count to 1; tables undefined.
`include "edge_set_closest_point_core_macros.svh"
module edge_set_closest_point_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [7:0]                          i_slot,
    input  logic signed [escp_pkg::CoordW-1:0]  i_coord_x,
    input  logic signed [escp_pkg::CoordW-1:0]  i_coord_y,
    input  logic signed [escp_pkg::CoordW-1:0]  i_coord_z,
    input  logic [7:0]                          i_end_a,
    input  logic [7:0]                          i_end_b,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [8:0]                          i_cfg_edge_count,
    output logic                                o_strobe,
    output logic signed [escp_pkg::CoordW-1:0]  o_closest_x,
    output logic signed [escp_pkg::CoordW-1:0]  o_closest_y,
    output logic signed [escp_pkg::CoordW-1:0]  o_closest_z,
    output logic [escp_pkg::DistW-1:0]          o_dist_sq
);
    localparam int unsigned VERTEX_DEPTH = escp_pkg::VertexDepth;
    localparam int unsigned EDGE_DEPTH   = escp_pkg::EdgeDepth;
    localparam int unsigned VaW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int unsigned EaW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(EDGE_DEPTH + 1) + 1;
    localparam int unsigned CW = escp_pkg::CoordW;
    localparam int unsigned DW = escp_pkg::DiffW;

    logic signed [CW-1:0] r_vx [VERTEX_DEPTH];
    logic signed [CW-1:0] r_vy [VERTEX_DEPTH];
    logic signed [CW-1:0] r_vz [VERTEX_DEPTH];
    logic [15:0]          r_ee [EDGE_DEPTH];

    escp_pkg::t_state r_state, n_state;
    logic [8:0]           r_edge_count;
    logic [CntW-1:0]      r_lim;
    logic [CntW-1:0]      r_idx;
    logic                 r_first;
    logic                 r_vsel;
    logic [2:0]           r_step;
    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic [15:0]          r_ends;
    logic signed [CW-1:0] r_a [3];
    logic signed [CW-1:0] r_b [3];
    logic signed [CW-1:0] r_vrd_x, r_vrd_y, r_vrd_z;
    logic signed [DW-1:0] r_v [3];
    logic signed [DW-1:0] r_w [3];
    logic signed [escp_pkg::DotW:0] r_dot, r_len;
    logic signed [CW:0]   r_c [3];
    logic [escp_pkg::DistW:0] r_dist;
    logic signed [CW-1:0] r_best [3];
    logic [escp_pkg::DistW-1:0] r_best_d;
    logic signed [DW-1:0] r_mul_a, r_mul_b;
    logic signed [2*DW-1:0] r_prod;
    logic [escp_pkg::FracW-1:0] r_t;
    logic                 r_div_start;
    logic                 r_strobe;

    logic                 div_done;
    logic [escp_pkg::FracW-1:0] div_quot;
    logic                 acc;
    logic [1:0]           k;
    logic [1:0]           m;
    logic signed [2*DW-1:0] n_prod;
    logic signed [DW-1:0] n_pa, n_pb;
    logic signed [CW-1:0] n_psel;
    logic signed [DW-1:0] n_d;

    assign acc = start && !busy;
    assign busy = (r_state != escp_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;
    assign k = r_step[1:0];
    assign m = r_step[1:0] + 2'd1;

    escp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_dot[escp_pkg::DotW-1:0]),
        .i_den   (r_len[escp_pkg::DotW-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // tables
    always_ff @(posedge i_clk) begin
        if (acc && i_req_type == escp_pkg::REQ_VERTEX) begin
            r_vx[i_slot[VaW-1:0]] <= i_coord_x;
            r_vy[i_slot[VaW-1:0]] <= i_coord_y;
            r_vz[i_slot[VaW-1:0]] <= i_coord_z;
        end
        if (acc && i_req_type == escp_pkg::REQ_EDGE)
            r_ee[i_slot[EaW-1:0]] <= {i_end_b, i_end_a};
        r_ends <= r_ee[r_idx[EaW-1:0]];
        r_vrd_x <= r_vx[r_vsel ? r_ends[8+:VaW] : r_ends[VaW-1:0]];
        r_vrd_y <= r_vy[r_vsel ? r_ends[8+:VaW] : r_ends[VaW-1:0]];
        r_vrd_z <= r_vz[r_vsel ? r_ends[8+:VaW] : r_ends[VaW-1:0]];
    end

    // shared multiplier operand select
    always_comb begin
        n_pa   = '0;
        n_pb   = '0;
        n_d    = '0;
        n_psel = (k == 2'd0) ? r_px : ((k == 2'd1) ? r_py : r_pz);
        unique case (r_state)
            escp_pkg::ST_MAC: begin
                if (r_step < 3'd3) begin
                    n_pa = r_v[k];
                    n_pb = r_w[k];
                end else if (r_step < 3'd6) begin
                    n_pa = r_v[m];
                    n_pb = r_v[m];
                end
            end
            escp_pkg::ST_PROJ: begin
                if (r_step < 3'd3) begin
                    n_pa = r_v[k];
                    n_pb = DW'($signed({1'b0, r_t}));
                end
            end
            escp_pkg::ST_DIST: begin
                if (r_step < 3'd3) begin
                    n_d  = DW'(n_psel) - r_c[k];
                    n_pa = n_d;
                    n_pb = n_d;
                end
            end
            default: ;
        endcase
        n_prod = r_mul_a * r_mul_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            escp_pkg::ST_IDLE:
                if (acc && i_req_type == escp_pkg::REQ_QUERY) n_state = escp_pkg::ST_FETCH_E;
            escp_pkg::ST_FETCH_E: n_state = escp_pkg::ST_FETCH_V;
            escp_pkg::ST_FETCH_V: if (r_step == 3'd3) n_state = escp_pkg::ST_DIFF;
            escp_pkg::ST_DIFF:    n_state = escp_pkg::ST_MAC;
            escp_pkg::ST_MAC:     if (r_step == 3'd7) n_state = escp_pkg::ST_DECIDE;
            escp_pkg::ST_DECIDE:
                if (r_dot <= 0 || r_dot >= r_len) n_state = escp_pkg::ST_DIST;
                else n_state = escp_pkg::ST_DIV;
            escp_pkg::ST_DIV:     if (div_done) n_state = escp_pkg::ST_PROJ;
            escp_pkg::ST_PROJ:    if (r_step == 3'd4) n_state = escp_pkg::ST_DIST;
            escp_pkg::ST_DIST:    if (r_step == 3'd4) n_state = escp_pkg::ST_CMP;
            escp_pkg::ST_CMP:     n_state = escp_pkg::ST_DONE;
            escp_pkg::ST_DONE:
                if (r_best_d == '0 || r_idx >= r_lim) n_state = escp_pkg::ST_IDLE;
                else n_state = escp_pkg::ST_FETCH_E;
            default: n_state = escp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= escp_pkg::ST_IDLE;
            r_edge_count <= 9'd1;
            r_strobe     <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= (r_state == escp_pkg::ST_DONE) && (n_state == escp_pkg::ST_IDLE);
            r_div_start <= (r_state == escp_pkg::ST_DECIDE) && (n_state == escp_pkg::ST_DIV);
            if (i_cfg_valid && o_cfg_ready) r_edge_count <= i_cfg_edge_count;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_mul_a <= n_pa;
        r_mul_b <= n_pb;
        r_prod  <= n_prod;
        if (r_state != n_state) r_step <= '0;
        else r_step <= r_step + 3'd1;
        unique case (r_state)
            escp_pkg::ST_IDLE: begin
                r_px <= i_coord_x; r_py <= i_coord_y; r_pz <= i_coord_z;
                r_idx <= '0;
                r_first <= 1'b1;
                r_vsel <= 1'b0;
                if (r_edge_count == 9'd0) r_lim <= CntW'(1);
                else if (CntW'(r_edge_count) > CntW'(EDGE_DEPTH)) r_lim <= CntW'(EDGE_DEPTH);
                else r_lim <= CntW'(r_edge_count);
            end
            escp_pkg::ST_FETCH_E: r_vsel <= 1'b0;
            escp_pkg::ST_FETCH_V: begin
                // step0: ends ready, A addr; step1: select B; step2: A data, B addr; step3: B data
                if (r_step == 3'd1) r_vsel <= 1'b1;
                if (r_step == 3'd2) begin
                    r_a[0] <= r_vrd_x; r_a[1] <= r_vrd_y; r_a[2] <= r_vrd_z;
                end
                if (r_step == 3'd3) begin
                    r_b[0] <= r_vrd_x; r_b[1] <= r_vrd_y; r_b[2] <= r_vrd_z;
                end
            end
            escp_pkg::ST_DIFF: begin
                r_v[0] <= DW'(r_b[0]) - DW'(r_a[0]);
                r_v[1] <= DW'(r_b[1]) - DW'(r_a[1]);
                r_v[2] <= DW'(r_b[2]) - DW'(r_a[2]);
                r_w[0] <= DW'(r_px) - DW'(r_a[0]);
                r_w[1] <= DW'(r_py) - DW'(r_a[1]);
                r_w[2] <= DW'(r_pz) - DW'(r_a[2]);
                r_dot <= '0;
                r_len <= '0;
            end
            escp_pkg::ST_MAC: begin
                // operands for product j issued at step j, registered in r_mul_a/r_mul_b, product registered in r_prod
                if (r_step >= 3'd2 && r_step <= 3'd4)
                    r_dot <= r_dot + (escp_pkg::DotW+1)'(r_prod);
                if (r_step >= 3'd5)
                    r_len <= r_len + (escp_pkg::DotW+1)'(r_prod);
            end
            escp_pkg::ST_DECIDE: begin
                if (r_dot <= 0) begin
                    r_c[0] <= (CW+1)'(r_a[0]); r_c[1] <= (CW+1)'(r_a[1]);
                    r_c[2] <= (CW+1)'(r_a[2]);
                end else begin
                    r_c[0] <= (CW+1)'(r_b[0]); r_c[1] <= (CW+1)'(r_b[1]);
                    r_c[2] <= (CW+1)'(r_b[2]);
                end
            end
            escp_pkg::ST_DIV: if (div_done) r_t <= div_quot;
            escp_pkg::ST_PROJ:
                if (r_step >= 3'd2)
                    r_c[r_step[1:0] - 2'd2] <= (CW+1)'(r_a[r_step[1:0] - 2'd2])
                        + (CW+1)'(r_prod >>> escp_pkg::FracW);
            escp_pkg::ST_DIST: begin
                if (r_step == 3'd0) r_dist <= '0;
                if (r_step >= 3'd2)
                    r_dist <= r_dist + (escp_pkg::DistW+1)'(r_prod);
            end
            escp_pkg::ST_CMP: begin
                if (r_first || r_dist[escp_pkg::DistW-1:0] < r_best_d) begin
                    r_best_d <= r_dist[escp_pkg::DistW-1:0];
                    r_best[0] <= r_c[0][CW-1:0];
                    r_best[1] <= r_c[1][CW-1:0];
                    r_best[2] <= r_c[2][CW-1:0];
                end
                r_first <= 1'b0;
                r_idx <= r_idx + CntW'(1);
            end
            default: ;
        endcase
    end

    assign o_strobe    = r_strobe;
    assign o_closest_x = r_best[0];
    assign o_closest_y = r_best[1];
    assign o_closest_z = r_best[2];
    assign o_dist_sq   = r_best_d;

    `ESCP_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `ESCP_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !busy)
    `ESCP_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, acc && i_req_type == escp_pkg::REQ_QUERY, busy)
endmodule

### verif/edge_set_closest_point_core_tb.sv
// Self-checking testbench for the edge set closest point core.
`timescale 1ns / 1ps
module edge_set_closest_point_core_tb;

    typedef struct {
        escp_pkg::t_req                     req;
        logic [7:0]                         slot;
        logic signed [escp_pkg::CoordW-1:0] x, y, z;
        logic [7:0]                         end_a, end_b;
    } t_item;

    typedef struct {
        logic signed [escp_pkg::CoordW-1:0] x, y, z;
        logic [escp_pkg::DistW-1:0]         dsq;
    } t_point;

    localparam logic signed [escp_pkg::CoordW-1:0] CMIN = 24'sh800000;
    localparam logic signed [escp_pkg::CoordW-1:0] CMAX = 24'sh7fffff;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [1:0]                         i_req_type = '0;
    logic [7:0]                         i_slot = '0;
    logic signed [escp_pkg::CoordW-1:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [7:0]                         i_end_a = '0, i_end_b = '0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [8:0]                         i_cfg_edge_count = '0;
    logic                               o_strobe;
    logic signed [escp_pkg::CoordW-1:0] o_closest_x, o_closest_y, o_closest_z;
    logic [escp_pkg::DistW-1:0]         o_dist_sq;

    edge_set_closest_point_core dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    longint     vtx_x [256], vtx_y [256], vtx_z [256];
    logic [7:0] edge_a [256], edge_b [256];
    int         search_count = 1;

    // generator shadow of what has been queued
    logic signed [escp_pkg::CoordW-1:0] gen_x [256], gen_y [256], gen_z [256];

    t_item  pending_q [$];
    t_point closest_q [$];
    t_item  cur;
    bit     taken = 0;
    bit     quiet = 0;
    int     gap = 0;
    int     errors = 0;
    int     n_queries = 0, n_writes = 0, n_results = 0;

    function automatic void seg_closest(input longint a [3], input longint b [3],
                                        input longint p [3], output longint c [3],
                                        output longint dsq);
        longint v [3], w [3];
        longint dot, len, r, t;
        dot = 0; len = 0; dsq = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = b[k] - a[k];
            w[k] = p[k] - a[k];
            dot += v[k] * w[k];
            len += v[k] * v[k];
        end
        if (dot <= 0) begin
            c = a;
        end else if (dot >= len) begin
            c = b;
        end else begin
            r = dot; t = 0;
            for (int k = 0; k < escp_pkg::FracW; k++) begin
                r = r <<< 1;
                t = t <<< 1;
                if (r >= len) begin
                    r -= len;
                    t |= 1;
                end
            end
            for (int k = 0; k < 3; k++) c[k] = a[k] + ((v[k] * t) >>> escp_pkg::FracW);
        end
        for (int k = 0; k < 3; k++) dsq += (p[k] - c[k]) * (p[k] - c[k]);
    endfunction

    function automatic t_point closest_on_edges(input t_item it);
        longint p [3], a [3], b [3], c [3], best [3];
        longint d, best_d;
        int     n;
        t_point res;
        p = '{longint'(it.x), longint'(it.y), longint'(it.z)};
        n = search_count < 1 ? 1 : (search_count > 256 ? 256 : search_count);
        best_d = -1;
        for (int e = 0; e < n && best_d != 0; e++) begin
            a = '{vtx_x[edge_a[e]], vtx_y[edge_a[e]], vtx_z[edge_a[e]]};
            b = '{vtx_x[edge_b[e]], vtx_y[edge_b[e]], vtx_z[edge_b[e]]};
            seg_closest(a, b, p, c, d);
            if (best_d < 0 || d < best_d) begin
                best_d = d;
                best = c;
            end
        end
        res.x = escp_pkg::CoordW'(best[0]);
        res.y = escp_pkg::CoordW'(best[1]);
        res.z = escp_pkg::CoordW'(best[2]);
        res.dsq = escp_pkg::DistW'(best_d);
        return res;
    endfunction

    // acceptance and table update
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            taken = 1;
            case (cur.req)
                escp_pkg::REQ_VERTEX: begin
                    vtx_x[cur.slot] = longint'(cur.x); vtx_y[cur.slot] = longint'(cur.y);
                    vtx_z[cur.slot] = longint'(cur.z);
                    n_writes++;
                end
                escp_pkg::REQ_EDGE: begin
                    edge_a[cur.slot] = cur.end_a; edge_b[cur.slot] = cur.end_b;
                    n_writes++;
                end
                escp_pkg::REQ_QUERY: begin
                    closest_q.push_back(closest_on_edges(cur));
                    n_queries++;
                end
                default: ;
            endcase
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || taken)) begin
            taken = 0;
            if (gap > 0) begin
                gap--;
                start <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                i_req_type <= cur.req;
                i_slot     <= cur.slot;
                i_coord_x  <= cur.x;
                i_coord_y  <= cur.y;
                i_coord_z  <= cur.z;
                i_end_a    <= cur.end_a;
                i_end_b    <= cur.end_b;
                start      <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (closest_q.size() == 0) begin
                $error("result with no query outstanding");
                errors++;
            end else begin
                want = closest_q.pop_front();
                if (o_closest_x !== want.x) begin
                    $error("closest_x expected %0d got %0d", want.x, o_closest_x);
                    errors++;
                end
                if (o_closest_y !== want.y) begin
                    $error("closest_y expected %0d got %0d", want.y, o_closest_y);
                    errors++;
                end
                if (o_closest_z !== want.z) begin
                    $error("closest_z expected %0d got %0d", want.z, o_closest_z);
                    errors++;
                end
                if (o_dist_sq !== want.dsq) begin
                    $error("dist_sq expected %0d got %0d", want.dsq, o_dist_sq);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [escp_pkg::CoordW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            3, 4: return escp_pkg::CoordW'($urandom);
            default: return escp_pkg::CoordW'($signed(15'($urandom)));
        endcase
    endfunction

    function automatic t_item mk(escp_pkg::t_req req, int slot,
                                 logic signed [escp_pkg::CoordW-1:0] x,
                                 logic signed [escp_pkg::CoordW-1:0] y,
                                 logic signed [escp_pkg::CoordW-1:0] z, int ea, int eb);
        t_item it;
        it.req = req; it.slot = 8'(slot); it.x = x; it.y = y; it.z = z;
        it.end_a = 8'(ea); it.end_b = 8'(eb);
        if (req == escp_pkg::REQ_VERTEX) begin
            gen_x[slot] = x; gen_y[slot] = y; gen_z[slot] = z;
        end
        return it;
    endfunction

    function automatic t_item rand_item();
        int sel, s;
        sel = $urandom_range(0, 19);
        s = $urandom_range(0, 255);
        if (sel < 5)
            return mk(escp_pkg::REQ_VERTEX, s, rand_coord(), rand_coord(), rand_coord(),
                      0, 0);
        if (sel < 10)
            return mk(escp_pkg::REQ_EDGE, s, rand_coord(), rand_coord(), rand_coord(), s,
                      $urandom_range(0, 3) == 0 ? s : $urandom_range(0, 255));
        if (sel == 10)
            return mk(escp_pkg::REQ_NONE, s, rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        if (sel < 14)
            return mk(escp_pkg::REQ_QUERY, s, gen_x[s], gen_y[s], gen_z[s],
                      $urandom_range(0, 255), $urandom_range(0, 255));
        return mk(escp_pkg::REQ_QUERY, s, rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_q.size() > 0 || start || closest_q.size() > 0 || busy);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_edge_count(int value);
        wait_idle();
        i_cfg_valid      <= 1'b1;
        i_cfg_edge_count <= 9'(value);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        search_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int counts [10] = '{2, 3, 5, 8, 16, 0, 4, 256, 511, 1};
        int per_phase;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one long edge between the corners, edge count at reset value
        pending_q.push_back(mk(escp_pkg::REQ_VERTEX, 0, CMIN, CMIN, CMIN, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_VERTEX, 1, CMAX, CMAX, CMAX, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_EDGE, 0, '0, '0, '0, 0, 1));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, '0, '0, '0, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMIN, CMAX, '0, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMIN, CMIN, CMIN, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMAX, CMAX, CMAX, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMAX, CMIN, CMAX, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, 24'sd4096, -24'sd77, 24'sd12345,
                               0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_NONE, 255, CMAX, CMAX, CMAX, 255, 255));
        pending_q.push_back(mk(escp_pkg::REQ_VERTEX, 2, 24'sd100, -24'sd100, 24'sd5, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_EDGE, 0, '0, '0, '0, 2, 2));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMIN, '0, CMAX, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, 24'sd100, -24'sd100, 24'sd5, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_EDGE, 1, '0, '0, '0, 1, 0));
        pending_q.push_back(mk(escp_pkg::REQ_EDGE, 0, '0, '0, '0, 0, 1));
        write_edge_count(2);
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, 24'sd3, CMAX, CMIN, 0, 0));
        pending_q.push_back(mk(escp_pkg::REQ_QUERY, 0, CMAX, CMAX, CMAX, 0, 0));

        // fill both tables so any later query reads written entries
        for (int s = 0; s < 256; s++)
            pending_q.push_back(mk(escp_pkg::REQ_VERTEX, s, rand_coord(), rand_coord(),
                                   rand_coord(), 0, 0));
        for (int s = 0; s < 256; s++)
            pending_q.push_back(mk(escp_pkg::REQ_EDGE, s, '0, '0, '0,
                                   $urandom_range(0, 255), $urandom_range(0, 255)));

        foreach (counts[i]) begin
            write_edge_count(counts[i]);
            per_phase = counts[i] >= 256 ? 6 : 50;
            if (i == 9) quiet = 1;
            for (int k = 0; k < per_phase; k++) pending_q.push_back(rand_item());
        end

        wait_idle();
        repeat (100) @(negedge i_clk);
        $display("Covered %0d table writes and %0d queries, %0d results checked,",
                 n_writes, n_queries, n_results);
        $display("edge counts from zero through saturation at 511.");
        if (errors == 0 && closest_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
